// ===== sv/x86d_pkg.sv =====
// Shared types, codes and opcode classification for the 8086 length decoder.
// Used by the front end, the back end and the top level; depends on nothing.

package x86d_pkg;

    // Default width of the running byte offset
    localparam int OFFSET_BITS_DEF = 16;
    // Default depth of the byte queue between front and back end
    localparam int QUEUE_DEPTH_DEF = 4;
    // Longest instruction this decoder recognizes
    localparam logic [2:0] MAX_LEN = 3'd6;
    // Second byte that AAM and AAD must carry
    localparam logic [7:0] AAM_BASE = 8'h0a;
    // ModRM field values that matter for operand lengths
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT  = 3'd6;

    typedef enum logic [3:0] {
        K_UNK   = 4'd0,
        K_ONE   = 4'd1,
        K_I8    = 4'd2,
        K_I16   = 4'd3,
        K_M     = 4'd4,
        K_MI8   = 4'd5,
        K_MI16  = 4'd6,
        K_MS8   = 4'd7,
        K_G3B   = 4'd8,
        K_G3W   = 4'd9,
        K_G4    = 4'd10,
        K_G5    = 4'd11,
        K_AAM   = 4'd12,
        K_FAR   = 4'd13,
        K_REL16 = 4'd14,
        K_REL8  = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNK_OP  = 2'd1,
        ST_UNK_EXT = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        instr_offset;
        logic [2:0]         instr_length;
        logic [7:0]         opcode_byte;
        logic [1:0]         status;
        logic               has_modrm;
        logic [7:0]         modrm_byte;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [15:0]        segment_value;
        logic [15:0]        branch_target;
    } t_out_item;

    // One queue word: the raw byte, its end-of-stream mark and its class
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        t_kind      kind;
    } t_qent;

    // Classify an opcode byte
    function automatic t_kind kind_of(input logic [7:0] op);
        t_kind k;
        k = K_UNK;
        if (op < 8'h40) begin
            if (op[2:0] <= 3'd3) begin
                k = K_M;
            end else if (op[2:0] == 3'd4) begin
                k = K_I8;
            end else if (op[2:0] == 3'd5) begin
                k = K_I16;
            end else begin
                case (op)
                    8'h06, 8'h07, 8'h0e, 8'h16, 8'h17,
                    8'h1e, 8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f: k = K_ONE;
                    default: k = K_UNK;
                endcase
            end
        end else if (op <= 8'h60) begin
            k = K_ONE;
        end else if (op >= 8'hb0 && op <= 8'hb7) begin
            k = K_I8;
        end else if (op >= 8'hb8 && op <= 8'hbf) begin
            k = K_I16;
        end else begin
            case (op)
                8'h80: k = K_MI8;
                8'h81: k = K_MI16;
                8'h83: k = K_MS8;
                8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8e: k = K_M;
                8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'hc2, 8'hca: k = K_I16;
                8'hc6: k = K_MI8;
                8'hc7: k = K_MI16;
                8'hcd: k = K_I8;
                8'h9c, 8'hc3, 8'hcb, 8'hcc, 8'hce, 8'hcf,
                8'hf4, 8'hf5, 8'hf8, 8'hfa, 8'hfc: k = K_ONE;
                8'hd4, 8'hd5: k = K_AAM;
                8'he9: k = K_REL16;
                8'hea: k = K_FAR;
                8'heb: k = K_REL8;
                8'hf6: k = K_G3B;
                8'hf7: k = K_G3W;
                8'hfe: k = K_G4;
                8'hff: k = K_G5;
                default: k = K_UNK;
            endcase
        end
        return k;
    endfunction

    function automatic logic kind_modrm(input t_kind k);
        return (k >= K_M) && (k <= K_G5);
    endfunction

    // Check the reg field of a group opcode
    function automatic logic ext_ok(input t_kind k, input logic [2:0] reg_f);
        logic ok;
        case (k)
            K_G3B, K_G3W: ok = (reg_f != 3'd1);
            K_G4:         ok = (reg_f < 3'd2);
            K_G5:         ok = (reg_f != 3'd7);
            default:      ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic logic [1:0] imm_len(input t_kind k, input logic [2:0] reg_f);
        logic [1:0] n;
        case (k)
            K_I8, K_MI8, K_MS8, K_REL8:     n = 2'd1;
            K_I16, K_MI16, K_REL16, K_FAR:  n = 2'd2;
            K_G3B:   n = (reg_f == 3'd0) ? 2'd1 : 2'd0;
            K_G3W:   n = (reg_f == 3'd0) ? 2'd2 : 2'd0;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] disp_len(input t_kind k, input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (kind_modrm(k)) begin
            case (modrm[7:6])
                MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
                MOD_DISP8:  n = 2'd1;
                MOD_DISP16: n = 2'd2;
                default:    n = 2'd0;
            endcase
        end
        return n;
    endfunction

endpackage

// ===== sv/x86d_fifo.sv =====
// Small register queue with registered pointers and a fill count.
// Stand-alone; no package needed.

module x86d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             v_push, v_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign v_push  = i_push && !o_full;
    assign v_pop   = i_pop && !o_empty;

    // Write the storage; no reset needed
    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (v_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
            end
            if (v_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
            end
            if (v_push && !v_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (v_pop && !v_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== sv/x86d_front.sv =====
// Front end: takes code bytes, classifies each one, and queues it.
// Depends on x86d_pkg and x86d_fifo.

module x86d_front #(
    parameter int QUEUE_DEPTH = x86d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  x86d_pkg::t_in_item i_data,
    output logic               o_q_valid,
    output x86d_pkg::t_qent    o_q_data,
    input  logic               i_q_pop
);
    import x86d_pkg::*;

    t_qent                  v_ent;
    logic [$bits(t_qent)-1:0] v_rdata;
    logic                   v_full, v_empty;

    // Classify the incoming byte on its way into the queue
    always_comb begin
        v_ent.code_byte = i_data.code_byte;
        v_ent.last_byte = i_data.last_byte;
        v_ent.kind      = kind_of(i_data.code_byte);
    end

    x86d_fifo #(
        .WIDTH($bits(t_qent)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_wdata (v_ent),
        .o_full  (v_full),
        .i_pop   (i_q_pop),
        .o_empty (v_empty),
        .o_rdata (v_rdata)
    );

    assign o_stall   = v_full;
    assign o_q_valid = !v_empty;
    assign o_q_data  = t_qent'(v_rdata);

endmodule

// ===== sv/x86d_back.sv =====
// Back end: parses queued bytes into instruction records, with an output
// register and a spare register for the second record of a byte.
// Depends on x86d_pkg.

module x86d_back #(
    parameter int OFFSET_BITS = x86d_pkg::OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  x86d_pkg::t_qent     i_q,
    output logic                o_q_pop,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    output logic                o_valid,
    input  logic                i_stall,
    output x86d_pkg::t_out_item o_data
);
    import x86d_pkg::*;

    typedef enum logic [3:0] {
        PH_OPC   = 4'd0,
        PH_MODRM = 4'd1,
        PH_DLO   = 4'd2,
        PH_DHI   = 4'd3,
        PH_ILO   = 4'd4,
        PH_IHI   = 4'd5,
        PH_SLO   = 4'd6,
        PH_SHI   = 4'd7,
        PH_CHK   = 4'd8
    } t_phase;

    // Parser state
    t_phase                 r_ph, n_ph;
    t_kind                  r_kind, n_kind;
    logic [7:0]             r_op, n_op;
    logic [7:0]             r_modrm, n_modrm;
    logic [15:0]            r_disp, n_disp;
    logic [15:0]            r_imm, n_imm;
    logic [15:0]            r_seg, n_seg;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [2:0]             r_cnt, n_cnt;
    logic [15:0]            r_start_cfg;
    logic                   r_fresh;

    // Output and spare record registers
    logic      r_out_vld, r_spr_vld;
    t_out_item r_out, r_spr;

    logic       v_take, v_out_free;
    logic [1:0] v_nrec;
    t_out_item  v_rec0, v_rec1, v_tmp;
    logic       v_beg, v_adv;
    t_phase     v_from, v_nxt;
    logic [7:0] v_b;

    // Next phase after an operand step; PH_OPC means the instruction is done
    function automatic t_phase next_phase(input t_phase from, input t_kind k,
                                          input logic [7:0] modrm);
        logic [1:0] d, i;
        logic       far;
        t_phase     p;
        d   = disp_len(k, modrm);
        i   = imm_len(k, modrm[5:3]);
        far = (k == K_FAR);
        case (from)
            PH_MODRM: p = (d != 2'd0) ? PH_DLO : (i != 2'd0) ? PH_ILO :
                          far ? PH_SLO : PH_OPC;
            PH_DLO:   p = (d == 2'd2) ? PH_DHI : (i != 2'd0) ? PH_ILO :
                          far ? PH_SLO : PH_OPC;
            PH_DHI:   p = (i != 2'd0) ? PH_ILO : far ? PH_SLO : PH_OPC;
            PH_ILO:   p = (i == 2'd2) ? PH_IHI : far ? PH_SLO : PH_OPC;
            PH_IHI:   p = far ? PH_SLO : PH_OPC;
            PH_SLO:   p = far ? PH_SHI : PH_OPC;
            default:  p = PH_OPC;
        endcase
        return p;
    endfunction

    // Build one record from a snapshot of the parser state
    function automatic t_out_item make_rec(
        input t_status st, input logic [OFFSET_BITS-1:0] start,
        input logic [2:0] cnt, input logic [7:0] op, input t_kind k,
        input logic [7:0] modrm, input logic [15:0] disp,
        input logic [15:0] imm, input logic [15:0] seg);
        t_out_item              r;
        logic                   hm;
        logic [OFFSET_BITS-1:0] rel, tgt;
        hm  = kind_modrm(k) && (cnt >= 3'd2);
        rel = (k == K_REL8) ? OFFSET_BITS'($signed(imm[7:0]))
                            : OFFSET_BITS'($signed(imm));
        tgt = '0;
        if (st == ST_OK && (k == K_REL16 || k == K_REL8)) begin
            tgt = start + OFFSET_BITS'(cnt) + rel;
        end
        r.instr_offset  = start[15:0];
        r.instr_length  = cnt;
        r.opcode_byte   = op;
        r.status        = st;
        r.has_modrm     = hm;
        r.modrm_byte    = hm ? modrm : 8'h00;
        r.displacement  = disp;
        r.immediate     = imm;
        r.segment_value = seg;
        r.branch_target = tgt[15:0];
        return r;
    endfunction

    assign v_out_free = !r_out_vld || !i_stall;
    assign v_take     = i_q_valid && !r_spr_vld && v_out_free;
    assign o_q_pop    = v_take;
    assign v_b        = i_q.code_byte;

    // Parse one byte; collect up to two records
    always_comb begin
        v_nrec  = 2'd0;
        v_rec0  = '0;
        v_rec1  = '0;
        v_tmp   = '0;
        v_beg   = 1'b0;
        v_adv   = 1'b0;
        v_from  = PH_MODRM;
        v_nxt   = PH_OPC;
        n_ph    = r_ph;
        n_kind  = r_kind;
        n_op    = r_op;
        n_modrm = r_modrm;
        n_disp  = r_disp;
        n_imm   = r_imm;
        n_seg   = r_seg;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_off   = r_off + OFFSET_BITS'(1);

        case (r_ph)
            PH_MODRM: begin
                if (!ext_ok(r_kind, v_b[5:3])) begin
                    v_rec0 = make_rec(ST_UNK_EXT, r_start, r_cnt, r_op, r_kind,
                                      r_modrm, r_disp, r_imm, r_seg);
                    v_nrec = 2'd1;
                    v_beg  = 1'b1;
                end else begin
                    n_modrm = v_b;
                    n_cnt   = 3'd2;
                    v_adv   = 1'b1;
                    v_from  = PH_MODRM;
                end
            end
            PH_CHK: begin
                if (v_b == AAM_BASE) begin
                    n_cnt  = 3'd2;
                    v_rec0 = make_rec(ST_OK, r_start, 3'd2, r_op, r_kind,
                                      r_modrm, r_disp, r_imm, r_seg);
                    v_nrec = 2'd1;
                    n_ph   = PH_OPC;
                end else begin
                    v_rec0 = make_rec(ST_UNK_EXT, r_start, r_cnt, r_op, r_kind,
                                      r_modrm, r_disp, r_imm, r_seg);
                    v_nrec = 2'd1;
                    v_beg  = 1'b1;
                end
            end
            PH_DLO: begin
                n_disp = (disp_len(r_kind, r_modrm) == 2'd1) ?
                         {{8{v_b[7]}}, v_b} : {8'h00, v_b};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_DLO;
            end
            PH_DHI: begin
                n_disp = {v_b, r_disp[7:0]};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_DHI;
            end
            PH_ILO: begin
                n_imm  = (r_kind == K_MS8) ? {{8{v_b[7]}}, v_b} : {8'h00, v_b};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_ILO;
            end
            PH_IHI: begin
                n_imm  = {v_b, r_imm[7:0]};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_IHI;
            end
            PH_SLO: begin
                n_seg  = {8'h00, v_b};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_SLO;
            end
            PH_SHI: begin
                n_seg  = {v_b, r_seg[7:0]};
                n_cnt  = r_cnt + 3'd1;
                v_adv  = 1'b1;
                v_from = PH_SHI;
            end
            default: begin
                v_beg = 1'b1;
            end
        endcase

        // Start a new instruction at this byte
        if (v_beg) begin
            n_start = r_off;
            n_op    = v_b;
            n_kind  = i_q.kind;
            n_modrm = 8'h00;
            n_cnt   = 3'd1;
            n_disp  = '0;
            n_imm   = '0;
            n_seg   = '0;
            n_ph    = PH_OPC;
            if (i_q.kind == K_UNK) begin
                v_tmp = make_rec(ST_UNK_OP, n_start, n_cnt, n_op, n_kind,
                                 n_modrm, n_disp, n_imm, n_seg);
                if (v_nrec == 2'd0) v_rec0 = v_tmp; else v_rec1 = v_tmp;
                v_nrec = v_nrec + 2'd1;
            end else if (i_q.kind == K_AAM) begin
                n_ph = PH_CHK;
            end else if (kind_modrm(i_q.kind)) begin
                n_ph = PH_MODRM;
            end else begin
                v_adv  = 1'b1;
                v_from = PH_MODRM;
            end
        end

        // Move to the next needed operand, or finish the instruction
        if (v_adv) begin
            v_nxt = next_phase(v_from, n_kind, n_modrm);
            if (v_nxt == PH_OPC) begin
                v_tmp = make_rec(ST_OK, n_start, n_cnt, n_op, n_kind,
                                 n_modrm, n_disp, n_imm, n_seg);
                if (v_nrec == 2'd0) v_rec0 = v_tmp; else v_rec1 = v_tmp;
                v_nrec = v_nrec + 2'd1;
            end
            n_ph = v_nxt;
        end

        // End of stream: report a partial instruction, reload the offset
        if (i_q.last_byte) begin
            if (n_ph != PH_OPC) begin
                v_tmp = make_rec(ST_TRUNC, n_start, n_cnt, n_op, n_kind,
                                 n_modrm, n_disp, n_imm, n_seg);
                if (v_nrec == 2'd0) v_rec0 = v_tmp; else v_rec1 = v_tmp;
                v_nrec = v_nrec + 2'd1;
            end
            n_ph  = PH_OPC;
            n_off = OFFSET_BITS'(r_start_cfg);
        end
    end

    // Hold parser state; load the start offset on a configuration write and update on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_OPC;
            r_kind      <= K_UNK;
            r_op        <= '0;
            r_modrm     <= '0;
            r_disp      <= '0;
            r_imm       <= '0;
            r_seg       <= '0;
            r_start     <= '0;
            r_cnt       <= '0;
            r_off       <= '0;
            r_start_cfg <= '0;
            r_fresh     <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_start_cfg <= i_cfg_wdata;
                if (r_fresh) begin
                    r_off <= OFFSET_BITS'(i_cfg_wdata);
                end
            end
            if (v_take) begin
                r_ph    <= n_ph;
                r_kind  <= n_kind;
                r_op    <= n_op;
                r_modrm <= n_modrm;
                r_disp  <= n_disp;
                r_imm   <= n_imm;
                r_seg   <= n_seg;
                r_start <= n_start;
                r_cnt   <= n_cnt;
                r_off   <= n_off;
                r_fresh <= i_q.last_byte;
            end
        end
    end

    // Drain spare first, else load new records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_spr_vld <= 1'b0;
        end else if (v_out_free) begin
            if (r_spr_vld) begin
                r_out_vld <= 1'b1;
                r_spr_vld <= 1'b0;
            end else begin
                r_out_vld <= v_take && (v_nrec != 2'd0);
                r_spr_vld <= v_take && (v_nrec == 2'd2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_out_free) begin
            if (r_spr_vld) begin
                r_out <= r_spr;
            end else begin
                r_out <= v_rec0;
                r_spr <= v_rec1;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Spare only ever holds the later of two records
    a_spare_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spr_vld |-> r_out_vld)
        else $error("spare record held without an output record");

    a_two_rec_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_take && v_nrec == 2'd2) |=> r_spr_vld)
        else $error("second record of a byte was dropped");

    a_unknown_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_UNK_OP) |-> (r_out.instr_length == 3'd1))
        else $error("unknown opcode record longer than one byte");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.instr_length != 3'd0 && r_out.instr_length <= MAX_LEN))
        else $error("record length out of range");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_take && i_q.last_byte && !i_cfg_we) |=>
            (r_ph == PH_OPC && r_fresh && r_off == OFFSET_BITS'(r_start_cfg)))
        else $error("parser not returned to stream start after final byte");

endmodule

// ===== sv/x86_16bit_instruction_decoder.sv =====
// Top level of the 8086 instruction length decoder: front end, byte queue
// and back end. Depends on x86d_pkg, x86d_front and x86d_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_data) carries one code byte per
//   word, with last_byte marking the final byte of a stream. Output channel
//   (o_valid / i_stall / o_data) carries one record per finished, unknown
//   or truncated instruction. i_cfg_we / i_cfg_wdata write the start offset;
//   write it only while no bytes are in flight.
// Timing: a byte accepted into the byte queue is parsed when the back end
//   pops it, and any record it closes is registered onto o_valid / o_data.
// Throughput: one byte per cycle while the output side is free and no spare
//   record waits. A byte that closes one instruction and opens another that
//   closes at once (bad group extension or a bad AAM/AAD second byte) yields
//   two records; the spare goes out before the next byte, which waits in the queue.
// Reset: queue empty, no record pending, parser awaiting an opcode, start
//   offset and running offset zero.
// Receiver stall: the output record holds; the back end stops pulling from
//   the queue, and o_stall rises once QUEUE_DEPTH bytes are waiting.

module x86_16bit_instruction_decoder #(
    parameter int OFFSET_BITS = x86d_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = x86d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  x86d_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output x86d_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import x86d_pkg::*;

    logic  v_q_valid, v_q_pop;
    t_qent v_q_data;

    x86d_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (v_q_valid),
        .o_q_data  (v_q_data),
        .i_q_pop   (v_q_pop)
    );

    x86d_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (v_q_valid),
        .i_q         (v_q_data),
        .o_q_pop     (v_q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

// ===== dv/x86_16bit_instruction_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 8086 instruction length decoder: streams code
// bytes, predicts each decoded record and checks it field by field.
// Depends on x86d_pkg and x86_16bit_instruction_decoder.

module x86_16bit_instruction_decoder_test;
    import x86d_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_BYTES   = 150;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 60;

    // Opcodes with special handling
    localparam logic [7:0] OP_ADD_MW    = 8'h01;
    localparam logic [7:0] OP_POP_ES    = 8'h07;
    localparam logic [7:0] OP_UNDEF_0F  = 8'h0f;
    localparam logic [7:0] OP_GRP1_B    = 8'h80;
    localparam logic [7:0] OP_GRP1_W    = 8'h81;
    localparam logic [7:0] OP_GRP1_SX   = 8'h83;
    localparam logic [7:0] OP_MOV_MI8   = 8'hc6;
    localparam logic [7:0] OP_MOV_MI16  = 8'hc7;
    localparam logic [7:0] OP_AAM       = 8'hd4;
    localparam logic [7:0] OP_AAD       = 8'hd5;
    localparam logic [7:0] OP_JMP_NEAR  = 8'he9;
    localparam logic [7:0] OP_JMP_FAR   = 8'hea;
    localparam logic [7:0] OP_JMP_SHORT = 8'heb;
    localparam logic [7:0] OP_GRP3_B    = 8'hf6;
    localparam logic [7:0] OP_GRP3_W    = 8'hf7;
    localparam logic [7:0] OP_GRP4      = 8'hfe;
    localparam logic [7:0] OP_GRP5      = 8'hff;
    // ModRM values used by the directed words
    localparam logic [7:0] MODRM_DIRECT  = {MOD_MEM, 3'd0, RM_DIRECT};
    localparam logic [7:0] MODRM_D8_R0   = {MOD_DISP8, 3'd0, 3'd5};
    localparam logic [7:0] MODRM_D16_R0  = {MOD_DISP16, 3'd0, 3'd0};
    localparam logic [7:0] MODRM_REG1_R3 = {2'd3, 3'd1, 3'd0};

    typedef enum logic [3:0] {
        AWAIT_OP, AWAIT_MODRM, DISP_LO, DISP_HI, IMM_LO, IMM_HI, SEG_LO, SEG_HI, AWAIT_0A
    } t_parse;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in_item    i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    // Decoder shadow state
    t_parse      parse_state;
    logic [7:0]  cur_op;
    logic [7:0]  cur_modrm;
    logic [15:0] disp_acc;
    logic [15:0] imm_acc;
    logic [15:0] seg_acc;
    logic [15:0] run_offset;
    logic [15:0] ins_start;
    logic [2:0]  ins_len;
    logic [15:0] base_offset;
    logic        stream_fresh;

    t_in_item  code_stream[$];
    t_in_item  phase_words[$];
    t_out_item pending_records[$];

    logic sender_gaps_on     = 1'b1;
    logic receiver_stalls_on = 1'b1;
    logic hold_request       = 1'b0;
    int   gap_left           = 0;
    int   stall_left         = 0;
    int   quiet_cycles       = 0;
    int   bytes_fed          = 0;
    int   streams_ended      = 0;
    int   records_checked    = 0;
    int   mismatches         = 0;
    int   status_seen[4]     = '{0, 0, 0, 0};

    x86_16bit_instruction_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Opcode table
    function automatic t_kind opcode_class(input logic [7:0] op);
        if (op < 8'h40) begin
            case (op[2:0])
                3'd4:    return K_I8;
                3'd5:    return K_I16;
                // segment pushes only exist for ES/CS/SS/DS, the rest are prefixes
                3'd6:    return (op < 8'h20) ? K_ONE : K_UNK;
                3'd7:    return (op == OP_UNDEF_0F) ? K_UNK : K_ONE;
                default: return K_M;
            endcase
        end
        if (op <= 8'h60) return K_ONE;
        if (op[7:4] == 4'hb) return op[3] ? K_I16 : K_I8;
        case (op)
            OP_GRP1_B, OP_MOV_MI8:                     return K_MI8;
            OP_GRP1_W, OP_MOV_MI16:                    return K_MI16;
            OP_GRP1_SX:                                return K_MS8;
            8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8e:  return K_M;
            8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'hc2, 8'hca:  return K_I16;
            8'hcd:                                     return K_I8;
            8'h9c, 8'hc3, 8'hcb, 8'hcc, 8'hce, 8'hcf,
            8'hf4, 8'hf5, 8'hf8, 8'hfa, 8'hfc:         return K_ONE;
            OP_AAM, OP_AAD:                            return K_AAM;
            OP_JMP_NEAR:                               return K_REL16;
            OP_JMP_FAR:                                return K_FAR;
            OP_JMP_SHORT:                              return K_REL8;
            OP_GRP3_B:                                 return K_G3B;
            OP_GRP3_W:                                 return K_G3W;
            OP_GRP4:                                   return K_G4;
            OP_GRP5:                                   return K_G5;
            default:                                   return K_UNK;
        endcase
    endfunction

    function automatic logic takes_modrm(input t_kind k);
        case (k)
            K_M, K_MI8, K_MI16, K_MS8, K_G3B, K_G3W, K_G4, K_G5: return 1'b1;
            default:                                             return 1'b0;
        endcase
    endfunction

    function automatic logic ext_valid(input t_kind k, input logic [2:0] reg_f);
        case (k)
            K_G3B, K_G3W: return reg_f != 3'd1;
            K_G4:         return reg_f[2:1] == 2'b00;
            K_G5:         return reg_f != 3'd7;
            default:      return 1'b1;
        endcase
    endfunction

    function automatic int disp_bytes(input t_kind k, input logic [7:0] modrm);
        if (!takes_modrm(k)) return 0;
        case (modrm[7:6])
            MOD_MEM:    return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
            MOD_DISP8:  return 1;
            MOD_DISP16: return 2;
            default:    return 0;
        endcase
    endfunction

    function automatic int imm_bytes(input t_kind k, input logic [2:0] reg_f);
        case (k)
            K_I8, K_MI8, K_MS8, K_REL8:    return 1;
            K_I16, K_MI16, K_REL16, K_FAR: return 2;
            K_G3B:                         return (reg_f == 3'd0) ? 1 : 0;
            K_G3W:                         return (reg_f == 3'd0) ? 2 : 0;
            default:                       return 0;
        endcase
    endfunction

    function automatic void reset_model();
        parse_state  = AWAIT_OP;
        cur_op       = '0;
        cur_modrm    = '0;
        disp_acc     = '0;
        imm_acc      = '0;
        seg_acc      = '0;
        base_offset  = '0;
        run_offset   = '0;
        ins_start    = '0;
        ins_len      = '0;
        stream_fresh = 1'b1;
    endfunction

    // Update the start offset; it reaches the running offset only between streams
    function automatic void model_start_offset(input logic [15:0] v);
        base_offset = v;
        if (stream_fresh) run_offset = v;
    endfunction

    // Queue the record for the instruction held so far
    function automatic void post_record(input t_status st);
        t_out_item r;
        t_kind     k;
        logic      modrm_seen;
        k          = opcode_class(cur_op);
        modrm_seen = takes_modrm(k) && (ins_len >= 3'd2);
        r               = '0;
        r.instr_offset  = ins_start;
        r.instr_length  = ins_len;
        r.opcode_byte   = cur_op;
        r.status        = st;
        r.has_modrm     = modrm_seen;
        r.modrm_byte    = modrm_seen ? cur_modrm : 8'h00;
        r.displacement  = disp_acc;
        r.immediate     = imm_acc;
        r.segment_value = seg_acc;
        if (st == ST_OK && k == K_REL16)
            r.branch_target = ins_start + 16'(ins_len) + imm_acc;
        else if (st == ST_OK && k == K_REL8)
            r.branch_target = ins_start + 16'(ins_len) + {{8{imm_acc[7]}}, imm_acc[7:0]};
        pending_records.push_back(r);
    endfunction

    function automatic logic field_needed(input t_parse p);
        t_kind k;
        int    dl;
        int    il;
        k  = opcode_class(cur_op);
        dl = disp_bytes(k, cur_modrm);
        il = imm_bytes(k, cur_modrm[5:3]);
        case (p)
            DISP_LO:        return dl >= 1;
            DISP_HI:        return dl == 2;
            IMM_LO:         return il >= 1;
            IMM_HI:         return il == 2;
            SEG_LO, SEG_HI: return k == K_FAR;
            default:        return 1'b0;
        endcase
    endfunction

    // Skip to the next operand field, or close the instruction
    function automatic void move_past(input t_parse from);
        t_parse p;
        p = t_parse'(from + 1);
        while (p <= SEG_HI && !field_needed(p)) p = t_parse'(p + 1);
        if (p > SEG_HI) begin
            post_record(ST_OK);
            parse_state = AWAIT_OP;
        end else begin
            parse_state = p;
        end
    endfunction

    function automatic void open_instr(input logic [7:0] b);
        t_kind k;
        k           = opcode_class(b);
        ins_start   = run_offset;
        cur_op      = b;
        cur_modrm   = '0;
        ins_len     = 3'd1;
        disp_acc    = '0;
        imm_acc     = '0;
        seg_acc     = '0;
        parse_state = AWAIT_OP;
        if (k == K_UNK)
            post_record(ST_UNK_OP);
        else if (k == K_AAM)
            parse_state = AWAIT_0A;
        else if (takes_modrm(k))
            parse_state = AWAIT_MODRM;
        else
            move_past(AWAIT_MODRM);
    endfunction

    // Advance the decoder by one accepted code byte
    function automatic void decode_byte(input t_in_item w);
        logic [7:0] b;
        t_kind      k;
        b = w.code_byte;
        k = opcode_class(cur_op);
        stream_fresh = 1'b0;
        case (parse_state)
            AWAIT_OP: open_instr(b);
            AWAIT_MODRM: begin
                if (!ext_valid(k, b[5:3])) begin
                    // reject the opcode, then decode this byte as a new one
                    post_record(ST_UNK_EXT);
                    open_instr(b);
                end else begin
                    cur_modrm = b;
                    ins_len   = 3'd2;
                    move_past(AWAIT_MODRM);
                end
            end
            AWAIT_0A: begin
                if (b == AAM_BASE) begin
                    ins_len = 3'd2;
                    post_record(ST_OK);
                    parse_state = AWAIT_OP;
                end else begin
                    post_record(ST_UNK_EXT);
                    open_instr(b);
                end
            end
            DISP_LO: begin
                disp_acc = (disp_bytes(k, cur_modrm) == 1) ? {{8{b[7]}}, b} : {8'h00, b};
                ins_len++;
                move_past(DISP_LO);
            end
            DISP_HI: begin
                disp_acc[15:8] = b;
                ins_len++;
                move_past(DISP_HI);
            end
            IMM_LO: begin
                imm_acc = (k == K_MS8) ? {{8{b[7]}}, b} : {8'h00, b};
                ins_len++;
                move_past(IMM_LO);
            end
            IMM_HI: begin
                imm_acc[15:8] = b;
                ins_len++;
                move_past(IMM_HI);
            end
            SEG_LO: begin
                seg_acc = {8'h00, b};
                ins_len++;
                move_past(SEG_LO);
            end
            SEG_HI: begin
                seg_acc[15:8] = b;
                ins_len++;
                move_past(SEG_HI);
            end
            default: open_instr(b);
        endcase
        run_offset++;
        // End of stream: report a partial instruction, reload the offset
        if (w.last_byte) begin
            if (parse_state != AWAIT_OP) post_record(ST_TRUNC);
            parse_state  = AWAIT_OP;
            run_offset   = base_offset;
            stream_fresh = 1'b1;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_record(input t_out_item got);
        t_out_item want;
        if (pending_records.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: unexpected record: expected none, actual offset %h opcode %h status %0d",
                         $time, got.instr_offset, got.opcode_byte, got.status);
            mismatches++;
            return;
        end
        want = pending_records.pop_front();
        records_checked++;
        status_seen[want.status]++;
        compare_field("instr_offset", want.instr_offset, got.instr_offset);
        compare_field("instr_length", 16'(want.instr_length), 16'(got.instr_length));
        compare_field("opcode_byte", 16'(want.opcode_byte), 16'(got.opcode_byte));
        compare_field("status", 16'(want.status), 16'(got.status));
        compare_field("has_modrm", 16'(want.has_modrm), 16'(got.has_modrm));
        compare_field("modrm_byte", 16'(want.modrm_byte), 16'(got.modrm_byte));
        compare_field("displacement", want.displacement, got.displacement);
        compare_field("immediate", want.immediate, got.immediate);
        compare_field("segment_value", want.segment_value, got.segment_value);
        compare_field("branch_target", want.branch_target, got.branch_target);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle(input logic enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        t_in_item w;
        w.code_byte = b;
        w.last_byte = last;
        phase_words.push_back(w);
    endfunction

    // Build one instruction with random content, mostly well-formed
    function automatic void gen_instruction();
        logic [7:0] op;
        logic [7:0] modrm;
        logic [7:0] ib[$];
        t_kind      k;
        int         tail;
        int         cut;
        int         i;
        logic       stop;
        tail = 0;
        op   = 8'($urandom_range(0, 255));
        k    = opcode_class(op);
        ib.push_back(op);
        if (k == K_AAM) begin
            ib.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : AAM_BASE);
        end else if (takes_modrm(k)) begin
            modrm = 8'($urandom_range(0, 255));
            // repair most bad group extensions
            if (!ext_valid(k, modrm[5:3]) && $urandom_range(0, 9) != 0)
                modrm[5:3] = (k == K_G4) ? 3'($urandom_range(0, 1)) : 3'd0;
            ib.push_back(modrm);
            tail = disp_bytes(k, modrm) + imm_bytes(k, modrm[5:3]);
        end else if (k != K_UNK) begin
            tail = imm_bytes(k, 3'd0) + ((k == K_FAR) ? 2 : 0);
        end
        for (i = 0; i < tail; i++) ib.push_back(8'($urandom_range(0, 255)));
        // End the stream now and then, sometimes mid-instruction
        cut = ib.size();
        if (cut > 1 && $urandom_range(0, 24) == 0) cut = $urandom_range(1, cut - 1);
        stop = (cut < ib.size()) || ($urandom_range(0, 11) == 0);
        for (i = 0; i < cut; i++) queue_byte(ib[i], stop && (i == cut - 1));
    endfunction

    function automatic void gen_noise();
        int n;
        int i;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endfunction

    // Special cases first; the stream ends on a truncated instruction
    function automatic void gen_directed();
        queue_byte(OP_ADD_MW, 1'b0);
        queue_byte(MODRM_DIRECT, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(OP_GRP1_SX, 1'b0);
        queue_byte(MODRM_D8_R0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(OP_GRP3_B, 1'b0);
        queue_byte(MODRM_REG1_R3, 1'b0);
        queue_byte(OP_AAM, 1'b0);
        queue_byte(AAM_BASE, 1'b0);
        queue_byte(OP_AAD, 1'b0);
        queue_byte(OP_POP_ES, 1'b0);
        queue_byte(OP_JMP_NEAR, 1'b0);
        queue_byte(8'hfd, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(OP_JMP_SHORT, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(OP_JMP_FAR, 1'b0);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(OP_GRP1_W, 1'b0);
        queue_byte(MODRM_D16_R0, 1'b0);
        queue_byte(8'h01, 1'b1);
    endfunction

    task automatic write_start_offset(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_start_offset(v);
        @(negedge i_clk);
    endtask

    task automatic release_phase();
        while (phase_words.size() != 0) code_stream.push_back(phase_words.pop_front());
    endtask

    // Hold off the sender until every record is back and the block is quiet
    task automatic drain_stream();
        while (code_stream.size() != 0 || i_valid || pending_records.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender: offer words from the stream, advance the decoder on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_data   <= '0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_byte(i_data);
                bytes_fed++;
                if (i_data.last_byte) streams_ended++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (code_stream.size() != 0) begin
                    i_data   <= code_stream.pop_front();
                    i_valid  <= 1'b1;
                    gap_left = pick_idle(sender_gaps_on);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted record, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) check_record(o_data);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                i_stall      <= 1'b1;
            end else begin
                stall_left = pick_idle(receiver_stalls_on);
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles, %0d records outstanding",
                         $time, IDLE_LIMIT, pending_records.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int          ph;
        logic [15:0] ofs;
        t_in_item    w;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed stream at the reset start offset
        gen_directed();
        release_phase();
        drain_stream();

        // Random phases, each with its own start offset and idling mix
        for (ph = 1; ph <= PHASES; ph++) begin
            case (ph)
                1:       ofs = 16'hfff0;
                2:       ofs = 16'hffff;
                3:       ofs = 16'h0000;
                default: ofs = 16'($urandom_range(0, 65535));
            endcase
            write_start_offset(ofs);
            sender_gaps_on     = (ph != 1) && (ph != 2);
            receiver_stalls_on = (ph != 1);
            // long receiver hold while the sender keeps offering
            if (ph == 2) hold_request = 1'b1;
            while (phase_words.size() < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 85) gen_instruction();
                else gen_noise();
            end
            // close every other phase so both write cases occur
            if (ph % 2 == 0) begin
                w = phase_words.pop_back();
                w.last_byte = 1'b1;
                phase_words.push_back(w);
            end
            release_phase();
            drain_stream();
        end

        $display("Fed %0d code bytes over %0d closed streams and %0d start offsets.",
                 bytes_fed, streams_ended, PHASES + 1);
        $display("Checked %0d records: %0d ok, %0d unknown opcode, %0d bad extension, %0d truncated.",
                 records_checked, status_seen[ST_OK], status_seen[ST_UNK_OP],
                 status_seen[ST_UNK_EXT], status_seen[ST_TRUNC]);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/x86d_pkg.sv
sv/x86d_fifo.sv
sv/x86d_front.sv
sv/x86d_back.sv
sv/x86_16bit_instruction_decoder.sv
dv/x86_16bit_instruction_decoder_test.sv
